/* rtl/core/scfe_pkg.sv */
`timescale 1ns / 1ps

package scfe_pkg;

	localparam int LEN_W     = 19;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 19;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC      = 15;

	// unity gain in Q1.15, one bit wider than a gain so it stays positive when signed
	localparam logic signed [GAIN_W:0] ONE_Q15 = 17'sd32768;

	localparam logic [LEN_W-1:0]  LEN_RST   = 19'd43200;
	localparam logic [GAIN_W-1:0] PAN_RST   = 16'd32896;
	localparam logic [GAIN_W-1:0] CROSS_RST = 16'd16512;
	localparam logic [GAIN_W-1:0] FB_RST    = 16'd15360;
	localparam logic [GAIN_W-1:0] DAMP_RST  = 16'd27607;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_LEN  = 3'd0,
		REG_RIGHT_LEN = 3'd1,
		REG_PAN       = 3'd2,
		REG_CROSS     = 3'd3,
		REG_FEEDBACK  = 3'd4,
		REG_DAMP      = 3'd5
	} cfg_reg_t;

	// accumulator control: load starts a new sum with the rounding half, add extends it
	typedef struct packed {
		logic load;
		logic add;
	} mac_ctl_t;

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
		return (g > ONE_Q15[GAIN_W-1:0]) ? ONE_Q15[GAIN_W-1:0] : g;
	endfunction

endpackage

/* rtl/core/scfe_if.sv */
`timescale 1ns / 1ps

interface scfe_in_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] left_sample;
	logic signed [W-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface scfe_out_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] left_out;
	logic signed [W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* rtl/core/scfe_mac.sv */
`timescale 1ns / 1ps

module scfe_mac
	import scfe_pkg::*;
#(
	parameter int A_W = 19,
	parameter int B_W = 17
) (
	input  logic                                clk,
	input  logic signed [A_W-1:0]               a,
	input  logic signed [B_W-1:0]               b,
	input  mac_ctl_t                            ctl,
	output logic signed [A_W+B_W+1-FRAC-1:0]    acc_rnd
);

	localparam int P_W   = A_W + B_W;
	localparam int ACC_W = P_W + 1;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);

	logic signed [P_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign prod_ext = {prod_s1[P_W-1], prod_s1};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= prod_ext + HALF;
		end else if (ctl.add) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// half already added at load, so the floor shift rounds half up
	assign acc_rnd = acc_q[ACC_W-1:FRAC];

endmodule

/* rtl/core/stereo_cross_feedback_echo.sv */
`timescale 1ns / 1ps
// Channel   Dir  Beat                         Handshake
// samples   in   left_sample, right_sample    valid/ready
// echo      out  left_out, right_out          valid/ready
// cfg       in   cfg_index, cfg_wdata         cfg_wr_en, no back-pressure
//
// After the accept, a stereo pair runs through the steps of one shared 19x17
// multiply-accumulate unit that forms all twelve products in turn.
// A new pair is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register; the final step holds until it is free.
// Reset needs no pass over the delay memories: an entry reads as zero until its
// store has wrapped once, which is when every entry in use has been written.

module stereo_cross_feedback_echo
	import scfe_pkg::*;
#(
	parameter int MAX_DELAY   = 262144,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	scfe_in_if.sink                 samples,
	scfe_out_if.source              echo,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata
);

	localparam int S   = SAMPLE_BITS;
	localparam int IW  = $clog2(MAX_DELAY);
	localparam int CW  = (IW + 1 > LEN_W) ? IW + 1 : LEN_W;
	localparam int A_W = S + 3;
	localparam int B_W = GAIN_W + 1;
	localparam int R_W = A_W + B_W + 1 - FRAC;

	localparam logic signed [S-1:0] S_MAX = {1'b0, {(S-1){1'b1}}};
	localparam logic signed [S-1:0] S_MIN = {1'b1, {(S-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// one multiply per step; products pair up into the sums ml, mr, wl, wr, yl, yr
	typedef enum logic [3:0] {
		K_ML0  = 4'd0,
		K_ML1  = 4'd1,
		K_MR0  = 4'd2,
		K_MR1  = 4'd3,
		K_WL0  = 4'd4,
		K_WL1  = 4'd5,
		K_WR0  = 4'd6,
		K_WR1  = 4'd7,
		K_YL0  = 4'd8,
		K_YL1  = 4'd9,
		K_YR0  = 4'd10,
		K_YR1  = 4'd11,
		K_WAIT = 4'd12,
		K_DONE = 4'd13
	} step_t;

	state_t state_q;
	step_t  step_q;

	// configuration
	logic [LEN_W-1:0]  llen_q, rlen_q;
	logic [GAIN_W-1:0] pan_q, cross_q, fb_q, damp_q;

	// delay line state
	logic [IW-1:0]       lidx_q, ridx_q;
	logic                lwrap_q, rwrap_q;
	logic signed [S-1:0] lprev_q, rprev_q;

	logic [S-1:0] lmem [MAX_DELAY];
	logic [S-1:0] rmem [MAX_DELAY];
	logic [S-1:0] lrd_q, rrd_q;

	// working registers
	logic signed [S-1:0]   xl_q, xr_q;
	logic signed [S-1:0]   ml_q, mr_q;
	logic signed [A_W-1:0] wl_q, wr_q;
	logic                  echo_valid_q;
	logic signed [S-1:0]   echo_l_q, echo_r_q;

	logic                  in_acc;
	logic                  run;
	logic                  done_ok;
	logic                  len_wr;
	logic signed [S-1:0]   tl, tr, yl, yr;
	logic signed [B_W-1:0] c_op, oc_op, pl_op, pr_op, nfb_op, d_op, od_op;
	logic signed [A_W-1:0] mac_a;
	logic signed [B_W-1:0] mac_b;
	mac_ctl_t              mac_ctl;
	logic signed [R_W-1:0] acc_rnd;
	logic [IW:0]           lnext, rnext;
	logic                  lwrap_now, rwrap_now;

	function automatic logic signed [S-1:0] sat_r(input logic signed [R_W-1:0] v);
		logic fits;
		fits = (v[R_W-1:S-1] == '0) || (&v[R_W-1:S-1]);
		if (fits) begin
			return v[S-1:0];
		end
		return v[R_W-1] ? S_MIN : S_MAX;
	endfunction

	// saturate twice the mix
	function automatic logic signed [S-1:0] sat_dbl(input logic signed [S-1:0] m);
		if (m[S-1] != m[S-2]) begin
			return m[S-1] ? S_MIN : S_MAX;
		end
		return {m[S-2:0], 1'b0};
	endfunction

	// zero length acts as one, lengths past the memory are cut to it
	function automatic logic [CW-1:0] eff_len(input logic [LEN_W-1:0] n);
		if (n == '0) begin
			return CW'(1);
		end
		if (CW'(n) > CW'(MAX_DELAY)) begin
			return CW'(MAX_DELAY);
		end
		return CW'(n);
	endfunction

	assign run           = (state_q == ST_RUN);
	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign done_ok       = run && (step_q == K_DONE) && (!echo_valid_q || echo.ready);
	assign len_wr        = cfg_wr_en && ((cfg_index == REG_LEFT_LEN) || (cfg_index == REG_RIGHT_LEN));

	assign echo.valid     = echo_valid_q;
	assign echo.left_out  = echo_l_q;
	assign echo.right_out = echo_r_q;

	// gain operands, all held as 17-bit signed
	assign c_op   = {1'b0, clamp_gain(cross_q)};
	assign oc_op  = ONE_Q15 - c_op;
	assign pl_op  = {1'b0, pan_q};
	assign pr_op  = ONE_Q15 - pl_op;      // negative once pan passes unity
	assign nfb_op = -$signed({1'b0, clamp_gain(fb_q)});
	assign d_op   = {1'b0, clamp_gain(damp_q)};
	assign od_op  = ONE_Q15 - d_op;

	// an entry not yet written since the last clear reads as zero
	assign tl = lwrap_q ? $signed(lrd_q) : '0;
	assign tr = rwrap_q ? $signed(rrd_q) : '0;

	always_comb begin
		mac_a = '0;
		mac_b = '0;
		case (step_q)
			K_ML0: begin mac_a = A_W'(tl);    mac_b = oc_op;  end
			K_ML1: begin mac_a = A_W'(tr);    mac_b = c_op;   end
			K_MR0: begin mac_a = A_W'(tr);    mac_b = oc_op;  end
			K_MR1: begin mac_a = A_W'(tl);    mac_b = c_op;   end
			K_WL0: begin mac_a = A_W'(xl_q);  mac_b = pl_op;  end
			K_WL1: begin mac_a = A_W'(ml_q);  mac_b = nfb_op; end
			K_WR0: begin mac_a = A_W'(xr_q);  mac_b = pr_op;  end
			K_WR1: begin mac_a = A_W'(mr_q);  mac_b = nfb_op; end
			K_YL0: begin mac_a = wl_q;        mac_b = d_op;   end
			K_YL1: begin mac_a = A_W'(lprev_q); mac_b = od_op; end
			K_YR0: begin mac_a = wr_q;        mac_b = d_op;   end
			K_YR1: begin mac_a = A_W'(rprev_q); mac_b = od_op; end
			default: begin mac_a = '0;        mac_b = '0;     end
		endcase
	end

	// each product is registered in the multiplier before it reaches the accumulator
	always_comb begin
		mac_ctl = '0;
		if (run) begin
			unique case (step_q) inside
				K_ML1, K_MR1, K_WL1, K_WR1, K_YL1, K_YR1: begin
					mac_ctl.load = 1'b1;
				end
				K_MR0, K_WL0, K_WR0, K_YL0, K_YR0, K_WAIT: begin
					mac_ctl.add = 1'b1;
				end
				default: begin
					mac_ctl = '0;
				end
			endcase
		end
	end

	scfe_mac #(
		.A_W (A_W),
		.B_W (B_W)
	) u_mac (
		.clk     (clk),
		.a       (mac_a),
		.b       (mac_b),
		.ctl     (mac_ctl),
		.acc_rnd (acc_rnd)
	);

	assign yl = sat_r(acc_rnd);
	assign yr = yl;

	// partial results, taken from the accumulator once both products of a sum are in
	always_ff @(posedge clk) begin
		if (in_acc) begin
			xl_q <= samples.left_sample;
			xr_q <= samples.right_sample;
		end
		if (run) begin
			case (step_q)
				K_MR1:   ml_q <= acc_rnd[S-1:0];
				K_WL1:   mr_q <= acc_rnd[S-1:0];
				K_WR1:   wl_q <= acc_rnd[A_W-1:0];
				K_YL1:   wr_q <= acc_rnd[A_W-1:0];
				default: ;
			endcase
		end
		if (done_ok) begin
			echo_l_q <= sat_dbl(ml_q);
			echo_r_q <= sat_dbl(mr_q);
		end
	end

	// delay memories: tap read on accept; left write-back at step K_YR1, right write-back at the final step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lrd_q <= lmem[lidx_q];
		end
		if (run && (step_q == K_YR1)) begin
			lmem[lidx_q] <= yl;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rrd_q <= rmem[ridx_q];
		end
		if (done_ok) begin
			rmem[ridx_q] <= yr;
		end
	end

	assign lnext     = {1'b0, lidx_q} + (IW+1)'(1);
	assign rnext     = {1'b0, ridx_q} + (IW+1)'(1);
	assign lwrap_now = CW'(lnext) >= eff_len(llen_q);
	assign rwrap_now = CW'(rnext) >= eff_len(rlen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= K_ML0;
			echo_valid_q <= 1'b0;
			llen_q       <= LEN_RST;
			rlen_q       <= LEN_RST;
			pan_q        <= PAN_RST;
			cross_q      <= CROSS_RST;
			fb_q         <= FB_RST;
			damp_q       <= DAMP_RST;
			lidx_q       <= '0;
			ridx_q       <= '0;
			lwrap_q      <= 1'b0;
			rwrap_q      <= 1'b0;
			lprev_q      <= '0;
			rprev_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						step_q  <= K_ML0;
					end
				end
				ST_RUN: begin
					if (step_q != K_DONE) begin
						step_q <= step_t'(step_q + 4'd1);
					end else if (done_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done_ok) begin
				echo_valid_q <= 1'b1;
			end else if (echo.ready) begin
				echo_valid_q <= 1'b0;
			end

			if (run && (step_q == K_YR1)) begin
				lprev_q <= yl;
			end

			if (done_ok) begin
				rprev_q <= yr;
				lidx_q  <= lwrap_now ? '0 : lnext[IW-1:0];
				ridx_q  <= rwrap_now ? '0 : rnext[IW-1:0];
				lwrap_q <= lwrap_q | lwrap_now;
				rwrap_q <= rwrap_q | rwrap_now;
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_LEFT_LEN:  llen_q  <= cfg_wdata[LEN_W-1:0];
					REG_RIGHT_LEN: rlen_q  <= cfg_wdata[LEN_W-1:0];
					REG_PAN:       pan_q   <= cfg_wdata[GAIN_W-1:0];
					REG_CROSS:     cross_q <= cfg_wdata[GAIN_W-1:0];
					REG_FEEDBACK:  fb_q    <= cfg_wdata[GAIN_W-1:0];
					REG_DAMP:      damp_q  <= cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end

			// any length write empties both lines
			if (len_wr) begin
				lidx_q  <= '0;
				ridx_q  <= '0;
				lwrap_q <= 1'b0;
				rwrap_q <= 1'b0;
				lprev_q <= '0;
				rprev_q <= '0;
			end
		end
	end

endmodule

/* rtl/core/scfe_checker.sv */
`timescale 1ns / 1ps

module scfe_checker #(
	parameter int W = 16
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] out_left,
	input logic [W-1:0] out_right
);

	logic [1:0] pend_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_left) && $stable(out_right))
		else $error("result beat changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown with no pair outstanding");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than one pair in work beside a waiting result");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("second pair taken while the first is in work");

endmodule

bind stereo_cross_feedback_echo scfe_checker #(
	.W (SAMPLE_BITS)
) u_scfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (echo.valid),
	.out_ready (echo.ready),
	.out_left  (echo.left_out),
	.out_right (echo.right_out)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import scfe_pkg::*;

	// register indexes the block does not decode: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	// cycles with no beat on either channel before the run is called hung
	localparam int HANG_LIMIT = 4000;

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] r;
	} echo_pair_t;

	// Echo predictor: own copy of the registers, both delay lines, the damping
	// state, and the queue of echo pairs still owed by the block.
	class echo_predictor;
		logic [CFG_W-1:0]   len_l, len_r;
		logic [GAIN_W-1:0]  pan, cross_g, fbk, damp;
		logic signed [15:0] line_l[int];
		logic signed [15:0] line_r[int];
		int                 tap_l, tap_r;
		longint             prev_l, prev_r;
		echo_pair_t         echo_due[$];
		int                 errors;

		function new();
			len_l   = LEN_RST;
			len_r   = LEN_RST;
			pan     = PAN_RST;
			cross_g = CROSS_RST;
			fbk     = FB_RST;
			damp    = DAMP_RST;
			errors  = 0;
			clear_lines();
		endfunction

		function void clear_lines();
			line_l.delete();
			line_r.delete();
			tap_l  = 0;
			tap_r  = 0;
			prev_l = 0;
			prev_r = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_LEFT_LEN: begin
					len_l = val;
					clear_lines();
				end
				REG_RIGHT_LEN: begin
					len_r = val;
					clear_lines();
				end
				REG_PAN:      pan     = val[GAIN_W-1:0];
				REG_CROSS:    cross_g = val[GAIN_W-1:0];
				REG_FEEDBACK: fbk     = val[GAIN_W-1:0];
				REG_DAMP:     damp    = val[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// round half up, floor divide by 2^15
		function longint q15(longint v);
			return (v + 64'sd16384) >>> 15;
		endfunction

		function logic signed [15:0] sat16(longint v);
			if (v > 32767)
				return 16'sh7fff;
			if (v < -32768)
				return 16'sh8000;
			return v[15:0];
		endfunction

		function longint unity_limit(logic [GAIN_W-1:0] g);
			return (g > 16'd32768) ? 64'sd32768 : longint'(g);
		endfunction

		function int span(logic [CFG_W-1:0] n);
			if (n == 0)
				return 1;
			if (n > 262144)
				return 262144;
			return int'(n);
		endfunction

		function void take_pair(logic signed [15:0] xl_in, logic signed [15:0] xr_in);
			longint     xl, xr, c, fb, d, pl, pr, tl, tr, ml, mr, wl, wr;
			logic signed [15:0] yl, yr;
			echo_pair_t e;
			xl = xl_in;
			xr = xr_in;
			c  = unity_limit(cross_g);
			fb = unity_limit(fbk);
			d  = unity_limit(damp);
			pl = longint'(pan);
			pr = 64'sd32768 - pl;   // negative once pan passes unity
			tl = line_l.exists(tap_l) ? longint'(line_l[tap_l]) : 0;
			tr = line_r.exists(tap_r) ? longint'(line_r[tap_r]) : 0;

			ml = q15(tl * (64'sd32768 - c) + tr * c);
			mr = q15(tr * (64'sd32768 - c) + tl * c);
			e.l = sat16(2 * ml);
			e.r = sat16(2 * mr);
			echo_due.push_back(e);

			wl = q15(xl * pl - ml * fb);
			wr = q15(xr * pr - mr * fb);
			yl = sat16(q15(wl * d + prev_l * (64'sd32768 - d)));
			yr = sat16(q15(wr * d + prev_r * (64'sd32768 - d)));

			line_l[tap_l] = yl;
			line_r[tap_r] = yr;
			prev_l = yl;
			prev_r = yr;
			tap_l = (tap_l + 1 >= span(len_l)) ? 0 : tap_l + 1;
			tap_r = (tap_r + 1 >= span(len_r)) ? 0 : tap_r + 1;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_echo(logic signed [15:0] l, logic signed [15:0] r);
			echo_pair_t e;
			if (echo_due.size() == 0) begin
				report($sformatf("echo beat %0d/%0d with nothing owed", l, r));
			end else begin
				e = echo_due.pop_front();
				if (l !== e.l)
					report($sformatf("left_out %0d, want %0d", l, e.l));
				if (r !== e.r)
					report($sformatf("right_out %0d, want %0d", r, e.r));
			end
		endtask

		function int owed();
			return echo_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	scfe_in_if  #(.W(16)) smp ();
	scfe_out_if #(.W(16)) ech ();

	stereo_cross_feedback_echo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp),
		.echo      (ech),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	echo_predictor echo_model = new();

	bit calm;          // last stretch: no gaps, no stalls
	int stall_left;
	int quiet_cycles;

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Echo sink: checks each beat, throttles ready in short random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			ech.ready <= 1'b0;
		end else begin
			if (ech.valid && ech.ready)
				echo_model.check_echo(ech.left_out, ech.right_out);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				ech.ready  <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 4);
				ech.ready  <= 1'b0;
			end else begin
				ech.ready <= 1'b1;
			end
		end
	end

	// Hang detection: any beat on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (smp.valid && smp.ready) || (ech.valid && ech.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Register write; the caller drops cfg_wr_en once the batch is done so that
	// back-to-back writes never toggle the enable within one step.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		echo_model.write_reg(idx, val);
	endtask

	task automatic wait_drain();
		while (echo_model.owed() != 0)
			@(posedge clk);
	endtask

	// Drop valid and let every owed echo come back before touching registers.
	task automatic settle();
		smp.valid <= 1'b0;
		wait_drain();
	endtask

	// One sample beat. With gaps on, it may idle a burst first, and now and
	// then hold off until the block has handed back everything owed.
	task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r,
			input bit gaps);
		bit pause;
		bit drain;
		pause = gaps && ($urandom_range(0, 3) == 0);
		drain = gaps && ($urandom_range(0, 59) == 0);
		if (pause || drain) begin
			smp.valid <= 1'b0;
			if (drain)
				wait_drain();
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		smp.valid        <= 1'b1;
		smp.left_sample  <= l;
		smp.right_sample <= r;
		do
			@(posedge clk);
		while (!smp.ready);
		echo_model.take_pair(l, r);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly short lines so echoes come round often; sometimes the odd lengths
	function automatic logic [CFG_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 19'd1;
			2:       return 19'd262144;
			3:       return '1;
			4:       return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(1, 48));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 19'd32768;
			2:       return '1;
			3:       return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic shuffle_settings();
		if ($urandom_range(0, 1))
			cfg_write(REG_LEFT_LEN, pick_len());
		if ($urandom_range(0, 1))
			cfg_write(REG_RIGHT_LEN, pick_len());
		if ($urandom_range(0, 3) != 0)
			cfg_write(REG_PAN, pick_gain());
		if ($urandom_range(0, 3) != 0)
			cfg_write(REG_CROSS, pick_gain());
		if ($urandom_range(0, 3) != 0)
			cfg_write(REG_FEEDBACK, pick_gain());
		if ($urandom_range(0, 3) != 0)
			cfg_write(REG_DAMP, pick_gain());
		if ($urandom_range(0, 5) == 0)
			cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_W'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		smp.valid        = 1'b0;
		smp.left_sample  = '0;
		smp.right_sample = '0;
		ech.ready        = 1'b0;
		calm             = 1'b0;
		stall_left       = 0;
		quiet_cycles     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: long lines, taps still read as cleared
		send_pair(16'sh7fff, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sh0000, 16'sh0000, 1'b1);
		send_pair(-16'sd1, 16'sd1, 1'b1);
		settle();

		// zero length acts as one, pan past unity flips the right gain,
		// gains past unity clamp; spare indexes must be ignored
		cfg_write(REG_LEFT_LEN, '0);
		cfg_write(REG_RIGHT_LEN, 19'd2);
		cfg_write(REG_PAN, '1);
		cfg_write(REG_CROSS, 19'd65535);
		cfg_write(REG_FEEDBACK, '0);
		cfg_write(REG_DAMP, 19'd65535);
		cfg_write(REG_SPARE_6, CFG_W'($urandom));
		cfg_write(REG_SPARE_7, CFG_W'($urandom));
		cfg_wr_en <= 1'b0;
		repeat (3) send_pair(16'sh7fff, 16'sh7fff, 1'b1);
		repeat (3) send_pair(16'sh8000, 16'sh8000, 1'b1);
		send_pair(16'sh7fff, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		repeat (2) send_pair(16'sh0000, 16'sh0000, 1'b1);
		settle();

		// oversize length saturates; zero pan, no cross, full feedback, full damping
		cfg_write(REG_LEFT_LEN, '1);
		cfg_write(REG_RIGHT_LEN, 19'd262144);
		cfg_write(REG_PAN, '0);
		cfg_write(REG_CROSS, '0);
		cfg_write(REG_FEEDBACK, 19'd32768);
		cfg_write(REG_DAMP, '0);
		cfg_wr_en <= 1'b0;
		send_pair(16'sh7fff, 16'sh7fff, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 1'b1);
		send_pair(16'sh1234, -16'sd4660, 1'b1);
		settle();

		// single-sample lines with full feedback: taps ring and saturate
		cfg_write(REG_LEFT_LEN, 19'd1);
		cfg_write(REG_RIGHT_LEN, 19'd1);
		cfg_write(REG_PAN, 19'd32768);
		cfg_write(REG_CROSS, 19'd16384);
		cfg_write(REG_DAMP, 19'd32768);
		cfg_wr_en <= 1'b0;
		send_pair(16'sh7fff, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sh7fff, 16'sh7fff, 1'b1);
		send_pair(16'sh0000, 16'sh0000, 1'b1);
		send_pair(16'sh0000, 16'sh0000, 1'b1);
		settle();

		// random settings and samples, with gaps and stalls
		repeat (8) begin
			shuffle_settings();
			repeat (45) send_pair(pick_sample(), pick_sample(), 1'b1);
			settle();
		end

		// closing stretch at full rate on both sides
		calm = 1'b1;
		shuffle_settings();
		repeat (40) send_pair(pick_sample(), pick_sample(), 1'b0);
		settle();
		repeat (40) @(posedge clk);

		if (echo_model.owed() != 0)
			echo_model.report($sformatf("%0d echo beats never came", echo_model.owed()));
		if (echo_model.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
